// ----- hw/rtl/rci_pkg.sv -----
package rci_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MUL_LAT       = 4;
  localparam int MIDQ_DEPTH    = 4;
  localparam int OUTQ_DEPTH    = 2;

  localparam int IDX_W = 3;
  localparam int CFG_W = 32;

  localparam logic [IDX_W-1:0] REG_END_A_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_END_A_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_END_A_Z = 3'd2;
  localparam logic [IDX_W-1:0] REG_END_B_X = 3'd3;
  localparam logic [IDX_W-1:0] REG_END_B_Y = 3'd4;
  localparam logic [IDX_W-1:0] REG_END_B_Z = 3'd5;
  localparam logic [IDX_W-1:0] REG_RADIUS  = 3'd6;

  localparam logic [30:0] RADIUS_RESET = 31'd13107;

  typedef logic signed [63:0] s64_t;
  typedef logic signed [32:0] d33_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec32_t;

  typedef struct packed {
    d33_t x;
    d33_t y;
    d33_t z;
  } vec33_t;

  typedef struct packed {
    vec32_t rd;
    vec33_t oa;
    vec33_t ob;
    vec33_t ba;
  } ray_t;

  localparam s64_t S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam s64_t S64_MIN = 64'sh8000_0000_0000_0000;

  function automatic s64_t sat65(input logic signed [64:0] v);
    if (v[64] != v[63]) return v[64] ? S64_MIN : S64_MAX;
    return v[63:0];
  endfunction

  function automatic s64_t sadd(input s64_t a, input s64_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    return sat65(s);
  endfunction

  function automatic s64_t ssub(input s64_t a, input s64_t b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    return sat65(s);
  endfunction

  function automatic s64_t sneg(input s64_t a);
    if (a == S64_MIN) return S64_MAX;
    return -a;
  endfunction

  function automatic s64_t sum3(input s64_t a, input s64_t b, input s64_t c);
    return sadd(sadd(a, b), c);
  endfunction

  function automatic s64_t sat_mag(input logic neg, input logic [127:0] m);
    if (|m[127:64]) return neg ? S64_MIN : S64_MAX;
    if (!neg) return m[63] ? S64_MAX : s64_t'(m[63:0]);
    if (m[63]) return S64_MIN;
    return -s64_t'(m[63:0]);
  endfunction

  function automatic logic [63:0] mag64(input s64_t v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic s64_t ext33(input d33_t v);
    return {{31{v[32]}}, v};
  endfunction

  function automatic s64_t ext32(input logic signed [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic signed [31:0] sat32(input s64_t v);
    if ((&v[63:31]) || !(|v[63:31])) return v[31:0];
    return v[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

endpackage

// ----- hw/rtl/ray_capsule_intersect.sv -----
// Channel   Direction  Handshake        Payload
// input     in         push / full      origin_x/y/z, dir_x/y/z
// result    out        empty / pop      hit, distance
// config    in         cfg_write        cfg_index, cfg_data
//
// One ray is taken every cycle and one result leaves every cycle when pop keeps up.
// An accepted item passes through the input queue, the back pipeline and the result
// queue; the length of the back pipeline is set mostly by the bit-per-stage divider
// and the two square root pipelines.
// Reset empties the queues, clears the pipeline valid bits and loads the capsule
// registers with their reset values.
// When the result queue is full the whole back pipeline holds; the input queue
// keeps taking items until it fills and then raises full.
module ray_capsule_intersect import rci_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] origin_z,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] dir_z,
  output logic               empty,
  input  logic               pop,
  output logic               hit,
  output logic signed [31:0] distance,
  input  logic               cfg_write,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  localparam int OW = $clog2(OUTQ_DEPTH);

  vec32_t      end_a, end_b;
  logic [30:0] radius;

  ray_t               ray;
  logic               ray_valid, ray_pop;
  logic               adv;
  logic               res_valid, res_hit;
  logic signed [31:0] res_dist;

  logic               hit_m  [0:OUTQ_DEPTH-1];
  logic signed [31:0] dist_m [0:OUTQ_DEPTH-1];
  logic [OW-1:0]      wp, rp;
  logic [OW:0]        cnt;
  logic               wr, rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      end_a  <= '0;
      end_b  <= '0;
      radius <= RADIUS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_END_A_X: end_a.x <= cfg_data;
        REG_END_A_Y: end_a.y <= cfg_data;
        REG_END_A_Z: end_a.z <= cfg_data;
        REG_END_B_X: end_b.x <= cfg_data;
        REG_END_B_Y: end_b.y <= cfg_data;
        REG_END_B_Z: end_b.z <= cfg_data;
        REG_RADIUS:  radius  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  rci_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
    .end_a(end_a), .end_b(end_b),
    .ray(ray), .ray_valid(ray_valid), .ray_pop(ray_pop)
  );

  rci_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .adv(adv),
    .ray(ray), .ray_valid(ray_valid), .ray_pop(ray_pop),
    .radius(radius),
    .res_valid(res_valid), .res_hit(res_hit), .res_dist(res_dist)
  );

  assign adv      = cnt != (OW+1)'(OUTQ_DEPTH);
  assign wr       = adv && res_valid;
  assign empty    = cnt == '0;
  assign rd       = pop && !empty;
  assign hit      = hit_m[rp];
  assign distance = dist_m[rp];

  always_ff @(posedge clk) begin
    if (wr) begin
      hit_m[wp]  <= res_hit;
      dist_m[wp] <= res_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      cnt <= cnt + (OW+1)'(wr) - (OW+1)'(rd);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= (OW+1)'(OUTQ_DEPTH))
    else $error("result queue count above depth");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !hit) |-> (distance == 32'sd0))
    else $error("missed item carries a nonzero distance");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (cnt == (OW+1)'(OUTQ_DEPTH) && !pop) |=> (cnt == (OW+1)'(OUTQ_DEPTH)))
    else $error("result queue overwritten while full");

  a_pop_moves: assert property (@(posedge clk) disable iff (rst)
    (rd && !wr) |=> (cnt == $past(cnt) - (OW+1)'(1)))
    else $error("result queue count lost a pop");

endmodule

// ----- hw/rtl/rci_delay.sv -----
module rci_delay import rci_pkg::*; #(
  parameter int W = 64,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sh [0:N-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sh[0] <= d;
      for (int i = 1; i < N; i++) begin
        sh[i] <= sh[i-1];
      end
    end
  end

  assign q = sh[N-1];

endmodule

// ----- hw/rtl/rci_fmul.sv -----
module rci_fmul import rci_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic en,
  input  s64_t x,
  input  s64_t y,
  output s64_t p
);

  logic         neg1, neg2, neg3;
  logic [63:0]  mx, my;
  logic [63:0]  pll, plh, phl, phh;
  logic [127:0] full;
  logic [127:0] shifted;
  logic         rest;

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= x[63] ^ y[63];
      mx   <= mag64(x);
      my   <= mag64(y);
      neg2 <= neg1;
      pll  <= mx[31:0]  * my[31:0];
      plh  <= mx[31:0]  * my[63:32];
      phl  <= mx[63:32] * my[31:0];
      phh  <= mx[63:32] * my[63:32];
      neg3 <= neg2;
      full <= {phh, 64'd0} + {32'd0, plh, 32'd0} + {32'd0, phl, 32'd0} + {64'd0, pll};
      p    <= sat_mag(neg3, shifted + 128'(neg3 & rest));
    end
  end

  assign shifted = full >> FRAC_BITS;
  assign rest    = |full[FRAC_BITS-1:0];

endmodule

// ----- hw/rtl/rci_sqrt.sv -----
module rci_sqrt import rci_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic en,
  input  s64_t h,
  output s64_t root
);

  localparam int NB = 64 + FRAC_BITS;
  localparam int RB = (NB + 1) / 2;
  localparam int NP = 2 * RB;
  localparam int RW = RB + 4;

  logic [NP-1:0] nq [0:RB-1];
  logic [RW-1:0] rq [0:RB];
  logic [RB-1:0] tq [0:RB];

  always_ff @(posedge clk) begin
    if (en) begin
      nq[0] <= (h > 64'sd0) ? NP'({h[62:0], {FRAC_BITS{1'b0}}}) : '0;
      rq[0] <= '0;
      tq[0] <= '0;
    end
  end

  for (genvar k = 1; k <= RB; k++) begin : g_step
    logic [RW-1:0] rs;
    logic [RW-1:0] tr;
    logic          ge;

    assign rs = {rq[k-1][RW-3:0], nq[k-1][NP-1:NP-2]};
    assign tr = {{(RW-RB-2){1'b0}}, tq[k-1], 2'b01};
    assign ge = rs >= tr;

    always_ff @(posedge clk) begin
      if (en) begin
        rq[k] <= ge ? (rs - tr) : rs;
        tq[k] <= {tq[k-1][RB-2:0], ge};
      end
    end

    if (k < RB) begin : g_shift
      always_ff @(posedge clk) begin
        if (en) begin
          nq[k] <= {nq[k-1][NP-3:0], 2'b00};
        end
      end
    end
  end

  assign root = {{(64-RB){1'b0}}, tq[RB]};

endmodule

// ----- hw/rtl/rci_div.sv -----
module rci_div import rci_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic en,
  input  s64_t n,
  input  s64_t d,
  output s64_t q
);

  localparam int NB = 64 + FRAC_BITS;

  logic          sg [0:NB];
  logic [63:0]   dm [0:NB];
  logic [NB-1:0] nb [0:NB];
  logic [63:0]   rm [0:NB];
  logic [NB-1:0] qq [0:NB];

  always_ff @(posedge clk) begin
    if (en) begin
      sg[0] <= n[63] ^ d[63];
      dm[0] <= mag64(d);
      nb[0] <= {mag64(n), {FRAC_BITS{1'b0}}};
      rm[0] <= '0;
      qq[0] <= '0;
      q     <= sat_mag(sg[NB], 128'(qq[NB]));
    end
  end

  for (genvar k = 1; k <= NB; k++) begin : g_step
    logic [64:0] rs;
    logic        ge;

    assign rs = {rm[k-1], nb[k-1][NB-1]};
    assign ge = rs >= {1'b0, dm[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        sg[k] <= sg[k-1];
        dm[k] <= dm[k-1];
        nb[k] <= {nb[k-1][NB-2:0], 1'b0};
        rm[k] <= ge ? 64'(rs - {1'b0, dm[k-1]}) : rs[63:0];
        qq[k] <= {qq[k-1][NB-2:0], ge};
      end
    end
  end

endmodule

// ----- hw/rtl/rci_front.sv -----
module rci_front import rci_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] origin_z,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] dir_z,
  input  vec32_t             end_a,
  input  vec32_t             end_b,
  output ray_t               ray,
  output logic               ray_valid,
  input  logic               ray_pop
);

  localparam int PW = $clog2(MIDQ_DEPTH);

  ray_t          mem [0:MIDQ_DEPTH-1];
  ray_t          item;
  logic [PW-1:0] wp, rp;
  logic [PW:0]   cnt;
  logic          wr;

  function automatic d33_t diff(input logic signed [31:0] a, input logic signed [31:0] b);
    return {a[31], a} - {b[31], b};
  endfunction

  always_comb begin
    item.rd.x = dir_x;
    item.rd.y = dir_y;
    item.rd.z = dir_z;
    item.oa.x = diff(origin_x, end_a.x);
    item.oa.y = diff(origin_y, end_a.y);
    item.oa.z = diff(origin_z, end_a.z);
    item.ob.x = diff(origin_x, end_b.x);
    item.ob.y = diff(origin_y, end_b.y);
    item.ob.z = diff(origin_z, end_b.z);
    item.ba.x = diff(end_b.x, end_a.x);
    item.ba.y = diff(end_b.y, end_a.y);
    item.ba.z = diff(end_b.z, end_a.z);
  end

  assign full      = cnt == (PW+1)'(MIDQ_DEPTH);
  assign wr        = push && !full;
  assign ray_valid = cnt != '0;
  assign ray       = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + PW'(1);
      if (ray_pop) rp <= rp + PW'(1);
      cnt <= cnt + (PW+1)'(wr) - (PW+1)'(ray_pop);
    end
  end

endmodule

// ----- hw/rtl/rci_back.sv -----
module rci_back import rci_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  ray_t               ray,
  input  logic               ray_valid,
  output logic               ray_pop,
  input  logic [30:0]        radius,
  output logic               res_valid,
  output logic               res_hit,
  output logic signed [31:0] res_dist
);

  localparam int NB  = 64 + FRAC_BITS;
  localparam int RB  = (NB + 1) / 2;
  localparam int M   = MUL_LAT;
  localparam int SQ  = RB + 1;
  localparam int DV  = NB + 2;
  localparam int T1  = M + 1;
  localparam int T2  = T1 + M + 1;
  localparam int T3  = T2 + M + 1;
  localparam int T4  = T3 + SQ + 1;
  localparam int T5  = T4 + DV;
  localparam int T6  = T5 + M + 1;
  localparam int T7  = T6 + 1;
  localparam int T8  = T7 + M + 1;
  localparam int T9  = T8 + M + 1;
  localparam int T10 = T9 + SQ + 1;
  localparam int LAT = T10 + 1;
  localparam int VW  = $bits(vec33_t);

  logic [LAT:0] vld;
  ray_t         r0;

  s64_t g1x [16], g1y [16], g1p [16];
  s64_t g2x [6],  g2y [6],  g2p [6];
  s64_t g3x [2],  g3y [2],  g3p [2];
  s64_t g7x [6],  g7y [6],  g7p [6];
  s64_t tb_p, b2b2;

  s64_t baba, bard, baoa, rdoa, oaoa, rr;
  s64_t a, b, c, h, num, t, y, b2, d2, h2, dist2;
  s64_t sq, sq2;
  s64_t baba_2, baba_6, bard_5, baoa_y, baoa_6, rr_9;
  s64_t a_4, a_6, b_4, t_10, d2_9, b2_10;
  logic hok_10, body, body_10, h2pos_10;
  vec33_t oc, oa_6, ob_6;
  vec32_t rd_7;
  s64_t yeff;

  assign ray_pop = adv && ray_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-1:0], ray_valid};
    end
  end

  // Stage 1: the five axis and ray dot products and r squared.
  always_comb begin
    g1x[0]  = ext33(r0.ba.x); g1y[0]  = ext33(r0.ba.x);
    g1x[1]  = ext33(r0.ba.y); g1y[1]  = ext33(r0.ba.y);
    g1x[2]  = ext33(r0.ba.z); g1y[2]  = ext33(r0.ba.z);
    g1x[3]  = ext33(r0.ba.x); g1y[3]  = ext32(r0.rd.x);
    g1x[4]  = ext33(r0.ba.y); g1y[4]  = ext32(r0.rd.y);
    g1x[5]  = ext33(r0.ba.z); g1y[5]  = ext32(r0.rd.z);
    g1x[6]  = ext33(r0.ba.x); g1y[6]  = ext33(r0.oa.x);
    g1x[7]  = ext33(r0.ba.y); g1y[7]  = ext33(r0.oa.y);
    g1x[8]  = ext33(r0.ba.z); g1y[8]  = ext33(r0.oa.z);
    g1x[9]  = ext32(r0.rd.x); g1y[9]  = ext33(r0.oa.x);
    g1x[10] = ext32(r0.rd.y); g1y[10] = ext33(r0.oa.y);
    g1x[11] = ext32(r0.rd.z); g1y[11] = ext33(r0.oa.z);
    g1x[12] = ext33(r0.oa.x); g1y[12] = ext33(r0.oa.x);
    g1x[13] = ext33(r0.oa.y); g1y[13] = ext33(r0.oa.y);
    g1x[14] = ext33(r0.oa.z); g1y[14] = ext33(r0.oa.z);
    g1x[15] = {33'd0, radius}; g1y[15] = {33'd0, radius};
  end

  always_comb begin
    g2x[0] = bard; g2y[0] = bard;
    g2x[1] = baba; g2y[1] = rdoa;
    g2x[2] = baoa; g2y[2] = bard;
    g2x[3] = baba; g2y[3] = oaoa;
    g2x[4] = baoa; g2y[4] = baoa;
    g2x[5] = rr;   g2y[5] = baba;
    g3x[0] = b;    g3y[0] = b;
    g3x[1] = a;    g3y[1] = c;
    g7x[0] = ext32(rd_7.x); g7y[0] = ext33(oc.x);
    g7x[1] = ext32(rd_7.y); g7y[1] = ext33(oc.y);
    g7x[2] = ext32(rd_7.z); g7y[2] = ext33(oc.z);
    g7x[3] = ext33(oc.x);   g7y[3] = ext33(oc.x);
    g7x[4] = ext33(oc.y);   g7y[4] = ext33(oc.y);
    g7x[5] = ext33(oc.z);   g7y[5] = ext33(oc.z);
  end

  for (genvar i = 0; i < 16; i++) begin : g_m1
    rci_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clk(clk), .en(adv), .x(g1x[i]), .y(g1y[i]), .p(g1p[i])
    );
  end

  for (genvar i = 0; i < 6; i++) begin : g_m2
    rci_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clk(clk), .en(adv), .x(g2x[i]), .y(g2y[i]), .p(g2p[i])
    );
  end

  for (genvar i = 0; i < 2; i++) begin : g_m3
    rci_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clk(clk), .en(adv), .x(g3x[i]), .y(g3y[i]), .p(g3p[i])
    );
  end

  for (genvar i = 0; i < 6; i++) begin : g_m7
    rci_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clk(clk), .en(adv), .x(g7x[i]), .y(g7y[i]), .p(g7p[i])
    );
  end

  rci_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_ty (
    .clk(clk), .en(adv), .x(t), .y(bard_5), .p(tb_p)
  );

  rci_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_b2 (
    .clk(clk), .en(adv), .x(b2), .y(b2), .p(b2b2)
  );

  rci_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt_body (
    .clk(clk), .en(adv), .h(h), .root(sq)
  );

  rci_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt_cap (
    .clk(clk), .en(adv), .h(h2), .root(sq2)
  );

  rci_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .en(adv), .n(num), .d(a_4), .q(t)
  );

  rci_delay #(.W(64), .N(M))          u_d_baba2 (.clk(clk), .en(adv), .d(baba), .q(baba_2));
  rci_delay #(.W(64), .N(T6-T1))      u_d_baba6 (.clk(clk), .en(adv), .d(baba), .q(baba_6));
  rci_delay #(.W(64), .N(T5-T1))      u_d_bard5 (.clk(clk), .en(adv), .d(bard), .q(bard_5));
  rci_delay #(.W(64), .N(T5+M-T1))    u_d_baoay (.clk(clk), .en(adv), .d(baoa), .q(baoa_y));
  rci_delay #(.W(64), .N(T6-T1))      u_d_baoa6 (.clk(clk), .en(adv), .d(baoa), .q(baoa_6));
  rci_delay #(.W(64), .N(T8+M-T1))    u_d_rr    (.clk(clk), .en(adv), .d(rr), .q(rr_9));
  rci_delay #(.W(64), .N(T4-T2))      u_d_a4    (.clk(clk), .en(adv), .d(a), .q(a_4));
  rci_delay #(.W(64), .N(T6-T2))      u_d_a6    (.clk(clk), .en(adv), .d(a), .q(a_6));
  rci_delay #(.W(64), .N(T4-1-T2))    u_d_b4    (.clk(clk), .en(adv), .d(b), .q(b_4));
  rci_delay #(.W(1),  .N(T10-T3))     u_d_hok   (.clk(clk), .en(adv), .d(!h[63]), .q(hok_10));
  rci_delay #(.W(64), .N(T10-T5))     u_d_t     (.clk(clk), .en(adv), .d(t), .q(t_10));
  rci_delay #(.W(1),  .N(T10-T7))     u_d_body  (.clk(clk), .en(adv), .d(body), .q(body_10));
  rci_delay #(.W(VW), .N(T6))         u_d_oa    (.clk(clk), .en(adv), .d(r0.oa), .q(oa_6));
  rci_delay #(.W(VW), .N(T6))         u_d_ob    (.clk(clk), .en(adv), .d(r0.ob), .q(ob_6));
  rci_delay #(.W($bits(vec32_t)), .N(T7)) u_d_rd (.clk(clk), .en(adv), .d(r0.rd), .q(rd_7));
  rci_delay #(.W(64), .N(M))          u_d_d2    (.clk(clk), .en(adv), .d(d2), .q(d2_9));
  rci_delay #(.W(64), .N(T10-1-T8))   u_d_b2    (.clk(clk), .en(adv), .d(b2), .q(b2_10));
  rci_delay #(.W(1),  .N(T10-T9))     u_d_h2    (.clk(clk), .en(adv), .d(h2 > 64'sd0),
                                                 .q(h2pos_10));

  assign yeff = (a_6 != 64'sd0) ? y : baoa_6;

  always_ff @(posedge clk) begin
    if (adv) begin
      r0    <= ray;
      baba  <= sum3(g1p[0],  g1p[1],  g1p[2]);
      bard  <= sum3(g1p[3],  g1p[4],  g1p[5]);
      baoa  <= sum3(g1p[6],  g1p[7],  g1p[8]);
      rdoa  <= sum3(g1p[9],  g1p[10], g1p[11]);
      oaoa  <= sum3(g1p[12], g1p[13], g1p[14]);
      rr    <= g1p[15];
      a     <= ssub(baba_2, g2p[0]);
      b     <= ssub(g2p[1], g2p[2]);
      c     <= ssub(ssub(g2p[3], g2p[4]), g2p[5]);
      h     <= ssub(g3p[0], g3p[1]);
      num   <= ssub(sneg(b_4), sq);
      y     <= sadd(baoa_y, tb_p);
      body  <= (a_6 != 64'sd0) && (y > 64'sd0) && (y < baba_6);
      oc    <= (yeff > 64'sd0) ? ob_6 : oa_6;
      b2    <= sum3(g7p[0], g7p[1], g7p[2]);
      d2    <= sum3(g7p[3], g7p[4], g7p[5]);
      h2    <= ssub(b2b2, ssub(d2_9, rr_9));
      dist2 <= ssub(sneg(b2_10), sq2);
      res_hit <= hok_10 && (body_10 || h2pos_10);
      if (!hok_10) begin
        res_dist <= '0;
      end else if (body_10) begin
        res_dist <= sat32(t_10);
      end else if (h2pos_10) begin
        res_dist <= sat32(dist2);
      end else begin
        res_dist <= '0;
      end
    end
  end

  assign res_valid = vld[LAT];

endmodule

// ----- tb/sv/tb_ray_capsule_intersect.sv -----
`timescale 1ns / 1ps

module tb_ray_capsule_intersect import rci_pkg::*;;

  localparam int FB = 16;
  localparam longint LIMIT_CYCLES = 2000000;
  localparam int TAIL_CYCLES = 400;

  typedef logic signed [63:0] fx_t;
  typedef logic signed [31:0] w32_t;

  typedef struct packed {
    w32_t ox, oy, oz, dx, dy, dz;
  } ray_item_t;

  typedef struct packed {
    logic hit;
    w32_t distance;
  } hit_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  w32_t origin_x = '0, origin_y = '0, origin_z = '0;
  w32_t dir_x = '0, dir_y = '0, dir_z = '0;
  logic empty;
  logic pop = 1'b0;
  logic hit;
  w32_t distance;
  logic cfg_write = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  ray_capsule_intersect #(.FRAC_BITS(FB)) uut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
    .empty(empty), .pop(pop), .hit(hit), .distance(distance),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Capsule copy held by the predictor.
  fx_t cap_a [3];
  fx_t cap_b [3];
  fx_t cap_r;

  ray_item_t pending_rays[$];
  hit_result_t expected_hits[$];
  int errors = 0;
  longint cycle = 0;
  bit hold_sender = 1'b0;
  bit long_stall_req = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_left = 0;

  function automatic fx_t f_sat(logic signed [65:0] v);
    if (v > 66'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (v < -66'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return v[63:0];
  endfunction

  function automatic fx_t f_add(fx_t a, fx_t b);
    return f_sat(66'(a) + 66'(b));
  endfunction

  function automatic fx_t f_sub(fx_t a, fx_t b);
    return f_sat(66'(a) - 66'(b));
  endfunction

  function automatic fx_t f_neg(fx_t a);
    return f_sat(-66'(a));
  endfunction

  function automatic fx_t f_mul(fx_t x, fx_t y);
    logic signed [129:0] p;
    logic signed [129:0] q;
    p = 130'(x) * 130'(y);
    q = p >>> FB;
    if (q > 130'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (q < -130'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return q[63:0];
  endfunction

  function automatic fx_t f_dot(fx_t u[3], fx_t v[3]);
    return f_add(f_add(f_mul(u[0], v[0]), f_mul(u[1], v[1])), f_mul(u[2], v[2]));
  endfunction

  function automatic fx_t f_root(fx_t h);
    logic [127:0] n;
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    if (h <= 0) return 0;
    n = 128'(h) << FB;
    for (int bit_i = 47; bit_i >= 0; bit_i--) begin
      c = r | (64'd1 << bit_i);
      if (128'(c) * 128'(c) <= n) r = c;
    end
    return r;
  endfunction

  function automatic fx_t f_div(fx_t n, fx_t d);
    logic signed [129:0] num;
    logic signed [129:0] q;
    num = 130'(n) <<< FB;
    q = num / 130'(d);
    if (q > 130'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (q < -130'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return q[63:0];
  endfunction

  function automatic hit_result_t predict_capsule_hit(ray_item_t r);
    fx_t ro[3], rd[3], ba[3], oa[3], ob[3], oc[3];
    fx_t baba, bard, baoa, rdoa, oaoa, a, b, c, h, rr, y, t, dist_v, b2, c2, h2;
    hit_result_t res;
    ro[0] = r.ox; ro[1] = r.oy; ro[2] = r.oz;
    rd[0] = r.dx; rd[1] = r.dy; rd[2] = r.dz;
    res.hit = 1'b0;
    dist_v = 0;
    for (int i = 0; i < 3; i++) begin
      ba[i] = f_sub(cap_b[i], cap_a[i]);
      oa[i] = f_sub(ro[i], cap_a[i]);
      ob[i] = f_sub(ro[i], cap_b[i]);
    end
    baba = f_dot(ba, ba);
    bard = f_dot(ba, rd);
    baoa = f_dot(ba, oa);
    rdoa = f_dot(rd, oa);
    oaoa = f_dot(oa, oa);
    rr = f_mul(cap_r, cap_r);
    a = f_sub(baba, f_mul(bard, bard));
    b = f_sub(f_mul(baba, rdoa), f_mul(baoa, bard));
    c = f_sub(f_sub(f_mul(baba, oaoa), f_mul(baoa, baoa)), f_mul(rr, baba));
    h = f_sub(f_mul(b, b), f_mul(a, c));
    if (h >= 0) begin
      t = 0;
      y = baoa;
      if (a != 0) begin
        t = f_div(f_sub(f_neg(b), f_root(h)), a);
        y = f_add(baoa, f_mul(t, bard));
      end
      if (a != 0 && y > 0 && y < baba) begin
        res.hit = 1'b1;
        dist_v = t;
      end else begin
        for (int i = 0; i < 3; i++) begin
          oc[i] = (y <= 0) ? oa[i] : ob[i];
        end
        b2 = f_dot(rd, oc);
        c2 = f_sub(f_dot(oc, oc), rr);
        h2 = f_sub(f_mul(b2, b2), c2);
        if (h2 > 0) begin
          res.hit = 1'b1;
          dist_v = f_sub(f_neg(b2), f_root(h2));
        end
      end
    end
    if (dist_v > 64'sh7FFF_FFFF) dist_v = 64'sh7FFF_FFFF;
    if (dist_v < -64'sh8000_0000) dist_v = -64'sh8000_0000;
    res.distance = dist_v[31:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle, what, got, want);
    errors++;
  endtask

  task automatic add_ray(ray_item_t r);
    pending_rays = {pending_rays, r};
  endtask

  // Driver: bursts and gaps, fed from the pending queue. The head of the queue is
  // the item on the ports while push is high.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (!rst && !(push && full)) begin
      if (push) void'(pending_rays.pop_front());
      if (push && burst_left > 1 && !hold_sender && pending_rays.size() > 0) begin
        burst_left <= burst_left - 1;
        {origin_x, origin_y, origin_z, dir_x, dir_y, dir_z} <= pending_rays[0];
        expected_hits = {expected_hits, predict_capsule_hit(pending_rays[0])};
      end else if (push) begin
        push <= 1'b0;
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (!hold_sender && pending_rays.size() > 0) begin
        push <= 1'b1;
        burst_left <= $urandom_range(1, 20);
        {origin_x, origin_y, origin_z, dir_x, dir_y, dir_z} <= pending_rays[0];
        expected_hits = {expected_hits, predict_capsule_hit(pending_rays[0])};
      end
    end
  end

  // Monitor and receiver stall pattern.
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        if (expected_hits.size() == 0) begin
          report_mismatch("unexpected result, hit", hit, 0);
        end else begin
          if (hit !== expected_hits[0].hit) report_mismatch("hit", hit, expected_hits[0].hit);
          if (distance !== expected_hits[0].distance)
            report_mismatch("distance", distance, expected_hits[0].distance);
          void'(expected_hits.pop_front());
        end
      end
      if (long_stall_req) begin
        long_stall_req <= 1'b0;
        stall_left <= 300;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        pop <= 1'b0;
      end else if (cycle % 2000 < 700) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  function automatic w32_t rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'sh8000_0000 | ($urandom() & 32'h1);
      default: return $signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000;
    endcase
  endfunction

  function automatic ray_item_t rnd_ray(bit aimed);
    ray_item_t r;
    r.ox = rnd_coord(); r.oy = rnd_coord(); r.oz = rnd_coord();
    if (aimed) begin
      r.ox = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      r.oy = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      r.oz = -32'sh0003_0000;
      r.dx = $signed($urandom_range(0, 32'h4000)) - 32'sh2000;
      r.dy = $signed($urandom_range(0, 32'h4000)) - 32'sh2000;
      r.dz = 32'sh0000_FC00 + $signed($urandom_range(0, 32'h800));
    end else begin
      r.dx = rnd_coord(); r.dy = rnd_coord(); r.dz = rnd_coord();
    end
    return r;
  endfunction

  function automatic ray_item_t mk_ray(w32_t ox, oy, oz, dx, dy, dz);
    ray_item_t r;
    r.ox = ox; r.oy = oy; r.oz = oz; r.dx = dx; r.dy = dy; r.dz = dz;
    return r;
  endfunction

  task automatic drain_and_settle();
    while (pending_rays.size() > 0 || push || expected_hits.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx <= REG_END_A_Z) cap_a[idx] = $signed(val);
    else if (idx <= REG_END_B_Z) cap_b[idx - REG_END_B_X] = $signed(val);
    else if (idx == REG_RADIUS) cap_r = {33'd0, val[30:0]};
  endtask

  task automatic set_capsule(w32_t ax, ay, az, bx, by, bz, logic [31:0] rad);
    write_reg(REG_END_A_X, ax); write_reg(REG_END_A_Y, ay); write_reg(REG_END_A_Z, az);
    write_reg(REG_END_B_X, bx); write_reg(REG_END_B_Y, by); write_reg(REG_END_B_Z, bz);
    write_reg(REG_RADIUS, rad);
    cfg_write <= 1'b0;
  endtask

  initial begin
    for (int i = 0; i < 3; i++) begin
      cap_a[i] = 0;
      cap_b[i] = 0;
    end
    cap_r = 64'(RADIUS_RESET);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Degenerate capsule at reset: a sphere of radius 0.2 at the origin.
    add_ray(mk_ray(0, 0, -32'sh0002_0000, 0, 0, 32'sh0001_0000));
    add_ray(mk_ray(0, 0, 0, 0, 0, 0));
    drain_and_settle();

    set_capsule(-32'sh0001_0000, 0, 0, 32'sh0001_0000, 0, 0, 32'h8000_8000);
    // Body hit, parallel rays into each cap, a miss with no root, rays starting inside.
    add_ray(mk_ray(0, 0, -32'sh0003_0000, 0, 0, 32'sh0001_0000));
    add_ray(mk_ray(-32'sh0005_0000, 0, 0, 32'sh0001_0000, 0, 0));
    add_ray(mk_ray(32'sh0005_0000, 0, 0, -32'sh0001_0000, 0, 0));
    add_ray(mk_ray(0, 32'sh0005_0000, 0, 32'sh0001_0000, 0, 0));
    add_ray(mk_ray(0, 0, 0, 0, 32'sh0001_0000, 0));
    add_ray(mk_ray(32'sh0001_8000, 0, -32'sh0003_0000, 0, 0, 32'sh0001_0000));
    add_ray(mk_ray(0, 0, -32'sh0003_0000, 0, 0, -32'sh0002_0000));
    add_ray(mk_ray(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                   32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    add_ray(mk_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                   32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    add_ray(mk_ray(-1, -1, -1, -1, -1, -1));
    add_ray(mk_ray(0, 0, 32'sh0003_0000, 0, 0, -32'sh0001_0000));
    drain_and_settle();

    set_capsule(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'h7FFF_FFFF);
    add_ray(mk_ray(0, 0, 0, 32'sh0001_0000, 0, 0));
    add_ray(mk_ray(32'sh7FFF_FFFF, 0, 32'sh8000_0000, 0, 32'sh0001_0000, 0));
    add_ray(rnd_ray(1'b0));
    drain_and_settle();

    set_capsule(0, 0, -32'sh0001_0000, 0, 0, 32'sh0001_0000, 0);
    add_ray(mk_ray(0, 0, -32'sh0003_0000, 0, 0, 32'sh0001_0000));
    add_ray(mk_ray(32'sh0000_0001, 0, 0, -32'sh0001_0000, 0, 0));
    drain_and_settle();

    for (int phase = 0; phase < 5; phase++) begin
      set_capsule($signed($urandom_range(0, 32'h6_0000)) - 32'sh3_0000,
                  $signed($urandom_range(0, 32'h6_0000)) - 32'sh3_0000,
                  -32'sh0001_0000 - $signed($urandom_range(0, 32'h2_0000)),
                  $signed($urandom_range(0, 32'h6_0000)) - 32'sh3_0000,
                  $signed($urandom_range(0, 32'h6_0000)) - 32'sh3_0000,
                  32'sh0001_0000 + $signed($urandom_range(0, 32'h2_0000)),
                  (phase == 4) ? $urandom() : $urandom_range(32'h2000, 32'h3_0000));
      if (phase == 2) begin
        long_stall_req = 1'b1;
      end
      for (int k = 0; k < 105; k++) add_ray(rnd_ray($urandom_range(0, 3) != 0));
      if (phase == 3) begin
        while (pending_rays.size() > 50) @(posedge clk);
        hold_sender = 1'b1;
        while (push || expected_hits.size() > 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      drain_and_settle();
    end

    if (errors == 0) begin
      $display("ray_capsule_intersect regression: pass");
    end else begin
      $display("ray_capsule_intersect regression: fail");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (cycle > LIMIT_CYCLES) begin
      $display("timeout at cycle %0d", cycle);
      $display("ray_capsule_intersect regression: fail");
      $finish;
    end
  end

endmodule

// ----- sim.f -----
hw/rtl/rci_pkg.sv
hw/rtl/rci_delay.sv
hw/rtl/rci_fmul.sv
hw/rtl/rci_sqrt.sv
hw/rtl/rci_div.sv
hw/rtl/rci_front.sv
hw/rtl/rci_back.sv
hw/rtl/ray_capsule_intersect.sv
tb/sv/tb_ray_capsule_intersect.sv
